// ===== rtl/lsas_pkg.sv =====
package lsas_pkg;

    localparam int ENCODER_COUNTS = 1024;
    localparam int ANGLE_W        = $clog2(ENCODER_COUNTS);
    localparam int MAX_STEP       = 5;
    localparam int SMALL_LIMIT    = 3;     // step sizes tried at low magnitude
    localparam int SMALL_MAG      = 27;    // magnitude at or below which SMALL_LIMIT applies
    localparam int IGNORE_ABOVE   = 50;    // speeds above this are ignored
    localparam int BASE_NUM       = 1875;  // numerator per unit of step size
    localparam int DEN_SHIFT      = 4;     // divisor = 16 * magnitude
    localparam int HALF_SHIFT     = 3;     // half divisor = 8 * magnitude

    localparam int SPEED_W = 8;
    localparam int TICK_W  = 32;
    localparam int MAG_W   = SPEED_W;                          // magnitude up to 128
    localparam int NUM_W   = $clog2(BASE_NUM * MAX_STEP + 1);
    localparam int DEN_W   = MAG_W + DEN_SHIFT;
    localparam int K_W     = $clog2(MAX_STEP + 1);
    localparam int STEP_W  = K_W + 1;
    localparam int IVL_W   = 9;
    localparam int CNT_W   = $clog2(NUM_W + 1);

    localparam int IN_W  = SPEED_W + TICK_W;                   // 40, already whole bytes
    localparam int OUT_W = ANGLE_W + IVL_W + STEP_W + 1;       // 24, already whole bytes

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quo;
        logic [DEN_W-1:0] rem;
    } div_res_t;

    typedef struct packed {
        logic             done;
        logic [IVL_W-1:0] ivl;
        logic [K_W-1:0]   k;
    } pick_res_t;

endpackage

// ===== rtl/lsas_div.sv =====
// Restoring divider, one quotient bit per cycle.
module lsas_div (
    input  logic              clk,
    input  logic              rst_n,
    input  lsas_pkg::div_req_t req,
    output lsas_pkg::div_res_t res
);
    import lsas_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;   // numerator bits shift out, quotient bits in

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            den_next  = req.den;
            rem_next  = '0;
            quo_next  = req.num;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = diff[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign res.done = done_reg;
    assign res.quo  = quo_reg;
    assign res.rem  = rem_reg;

endmodule

// ===== rtl/lsas_pick.sv =====
// Step-size search: one division per candidate step, first least error kept.
module lsas_pick (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [lsas_pkg::MAG_W-1:0] mag,
    output lsas_pkg::pick_res_t        res
);
    import lsas_pkg::*;

    typedef enum logic [1:0] {
        P_IDLE = 2'b01,
        P_WAIT = 2'b10
    } pick_state_t;

    pick_state_t      state_reg, state_next;
    logic             start_reg, start_next;
    logic             done_reg, done_next;
    logic             first_reg, first_next;
    logic [K_W-1:0]   k_reg, k_next;
    logic [K_W-1:0]   lim_reg, lim_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [MAG_W-1:0] mag_reg, mag_next;
    logic [DEN_W-1:0] best_err_reg, best_err_next;
    logic [IVL_W-1:0] best_ivl_reg, best_ivl_next;
    logic [K_W-1:0]   best_k_reg, best_k_next;

    div_req_t         dreq;
    div_res_t         dres;

    logic             rnd_up;
    logic [DEN_W-1:0] err;
    logic [NUM_W-1:0] q_rnd;

    assign dreq.start = start_reg;
    assign dreq.num   = num_reg;
    assign dreq.den   = den_reg;

    lsas_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .res   (dres)
    );

    // remainder of exactly half rounds down
    assign rnd_up = dres.rem > (DEN_W'(mag_reg) << HALF_SHIFT);
    assign err    = rnd_up ? (den_reg - dres.rem) : dres.rem;
    assign q_rnd  = dres.quo + NUM_W'(rnd_up);

    always_comb
    begin
        state_next    = state_reg;
        start_next    = 1'b0;
        done_next     = 1'b0;
        first_next    = first_reg;
        k_next        = k_reg;
        lim_next      = lim_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        mag_next      = mag_reg;
        best_err_next = best_err_reg;
        best_ivl_next = best_ivl_reg;
        best_k_next   = best_k_reg;
        unique case (state_reg)
            P_IDLE:
            begin
                if (start)
                begin
                    mag_next   = mag;
                    den_next   = DEN_W'(mag) << DEN_SHIFT;
                    lim_next   = (mag <= MAG_W'(SMALL_MAG) && MAX_STEP > SMALL_LIMIT)
                                 ? K_W'(SMALL_LIMIT) : K_W'(MAX_STEP);
                    num_next   = NUM_W'(BASE_NUM);
                    k_next     = K_W'(1);
                    first_next = 1'b1;
                    start_next = 1'b1;
                    state_next = P_WAIT;
                end
            end
            P_WAIT:
            begin
                if (dres.done)
                begin
                    first_next = 1'b0;
                    if (first_reg || err < best_err_reg)
                    begin
                        best_err_next = err;
                        best_ivl_next = q_rnd[IVL_W-1:0];   // chosen interval never exceeds 352
                        best_k_next   = k_reg;
                    end
                    if (k_reg == lim_reg)
                    begin
                        done_next  = 1'b1;
                        state_next = P_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + K_W'(1);
                        num_next   = num_reg + NUM_W'(BASE_NUM);
                        start_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            start_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg    <= first_next;
        k_reg        <= k_next;
        lim_reg      <= lim_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        mag_reg      <= mag_next;
        best_err_reg <= best_err_next;
        best_ivl_reg <= best_ivl_next;
        best_k_reg   <= best_k_next;
    end

    assign res.done = done_reg;
    assign res.ivl  = best_ivl_reg;
    assign res.k    = best_k_reg;

endmodule

// ===== rtl/low_speed_angle_stepper_unit.sv =====
// Low-speed open-loop angle stepper. Each request carries a signed target speed
// and the current free-running tick count; each produces exactly one result.
// Speeds above 50 are ignored (angle unchanged, interval 0, step 0). Zero speed
// uses interval 1 and step 0. Otherwise step sizes 1..5 (1..3 for magnitudes of
// 27 or less) are tried; for each, the rounded interval 1875*k/(16*|speed|) and
// its rounding error come from a shared bit-serial restoring divider, and the
// first size with the least error wins. When tick_now - last advance tick
// (mod 2^32) reaches the interval, the angle moves by the signed step and wraps
// into 0..1023. An ignored or zero-speed request skips the search and goes
// straight to the result; a searched request runs one division per step size
// tried (a divider load, 14 quotient bits, a result check), three sizes for
// magnitudes up to 27 and five above. The divider is the limiting unit;
// one request is in flight at a time. A new request is taken as soon as the
// previous result sits in the output register, even if it is not yet drained.
module low_speed_angle_stepper_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    // s_tdata: [7:0] speed_cmd (signed), [39:8] tick_now
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [lsas_pkg::IN_W-1:0]    s_tdata,
    // m_tdata: [9:0] angle, [18:10] interval_ticks, [22:19] angle_step (signed),
    //          [23] advanced
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [lsas_pkg::OUT_W-1:0]   m_tdata
);
    import lsas_pkg::*;

    typedef enum logic [2:0] {
        T_IDLE = 3'b001,   // waiting for a request
        T_PICK = 3'b010,   // step-size search running
        T_FIN  = 3'b100    // result ready, waiting for the output register
    } top_state_t;

    top_state_t         state_reg, state_next;

    // architectural state
    logic [ANGLE_W-1:0] angle_reg, angle_next;
    logic [TICK_W-1:0]  last_reg, last_next;

    // per-request working registers
    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic               neg_reg, neg_next;
    logic               ign_reg, ign_next;
    logic [IVL_W-1:0]   ivl_reg, ivl_next;
    logic [K_W-1:0]     k_reg, k_next;

    // output register
    logic               m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]   m_tdata_reg, m_tdata_next;

    logic signed [SPEED_W-1:0] in_speed;
    logic [TICK_W-1:0]  in_tick;
    logic               in_accept;
    logic [MAG_W-1:0]   in_mag;
    logic               pick_start;
    pick_res_t          pick_res;

    logic               out_free;
    logic signed [STEP_W-1:0]    step;
    logic [TICK_W-1:0]  elapsed;
    logic               adv;
    logic signed [ANGLE_W+1:0]   sum;
    logic signed [ANGLE_W+1:0]   wrapped;

    function automatic logic [TICK_W-1:0] tick_now_diff(input logic [TICK_W-1:0] a,
                                                        input logic [TICK_W-1:0] b);
        tick_now_diff = a - b;   // wraps mod 2^32
    endfunction

    assign in_speed  = s_tdata[SPEED_W-1:0];
    assign in_tick   = s_tdata[IN_W-1:SPEED_W];
    assign s_tready  = (state_reg == T_IDLE);
    assign in_accept = s_tvalid && s_tready;
    // two's complement negate; -128 gives magnitude 128 in 8 unsigned bits
    assign in_mag    = in_speed[SPEED_W-1] ? MAG_W'(-in_speed) : MAG_W'(in_speed);
    assign pick_start = in_accept && (in_speed <= SPEED_W'(IGNORE_ABOVE))
                        && (in_speed != '0);

    lsas_pick u_pick (
        .clk   (clk),
        .rst_n (rst_n),
        .start (pick_start),
        .mag   (in_mag),
        .res   (pick_res)
    );

    // advance decision and angle wrap, evaluated in T_FIN
    assign out_free = !m_tvalid_reg || m_tready;
    assign step     = neg_reg ? -$signed({1'b0, k_reg}) : $signed({1'b0, k_reg});
    assign elapsed  = tick_now_diff(tick_reg, last_reg);
    assign adv      = !ign_reg && (elapsed >= TICK_W'(ivl_reg));
    assign sum      = $signed({2'b00, angle_reg}) + (ANGLE_W+2)'(step);

    always_comb
    begin
        priority if (sum >= (ANGLE_W+2)'(ENCODER_COUNTS))
            wrapped = sum - (ANGLE_W+2)'(ENCODER_COUNTS);
        else if (sum < 0)
            wrapped = sum + (ANGLE_W+2)'(ENCODER_COUNTS);
        else
            wrapped = sum;
    end

    always_comb
    begin
        state_next    = state_reg;
        angle_next    = angle_reg;
        last_next     = last_reg;
        tick_next     = tick_reg;
        neg_next      = neg_reg;
        ign_next      = ign_reg;
        ivl_next      = ivl_reg;
        k_next        = k_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        unique case (state_reg)
            T_IDLE:
            begin
                if (in_accept)
                begin
                    tick_next = in_tick;
                    neg_next  = in_speed[SPEED_W-1];
                    ign_next  = 1'b0;
                    k_next    = '0;
                    priority if (in_speed > SPEED_W'(IGNORE_ABOVE))
                    begin
                        ign_next   = 1'b1;
                        ivl_next   = '0;
                        state_next = T_FIN;
                    end
                    else if (in_speed == '0)
                    begin
                        ivl_next   = IVL_W'(1);
                        state_next = T_FIN;
                    end
                    else
                    begin
                        state_next = T_PICK;
                    end
                end
            end
            T_PICK:
            begin
                if (pick_res.done)
                begin
                    ivl_next   = pick_res.ivl;
                    k_next     = pick_res.k;
                    state_next = T_FIN;
                end
            end
            T_FIN:
            begin
                if (out_free)
                begin
                    if (adv)
                    begin
                        angle_next = wrapped[ANGLE_W-1:0];
                        last_next  = tick_reg;
                    end
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {adv,
                                     (ign_reg ? STEP_W'(0) : step),
                                     ivl_reg,
                                     (adv ? wrapped[ANGLE_W-1:0] : angle_reg)};
                    state_next    = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= T_IDLE;
            angle_reg    <= '0;
            last_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            angle_reg    <= angle_next;
            last_reg     <= last_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tick_reg    <= tick_next;
        neg_reg     <= neg_next;
        ign_reg     <= ign_next;
        ivl_reg     <= ivl_next;
        k_reg       <= k_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== tb/sv/lsas_angle_checker.sv =====
module lsas_angle_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [lsas_pkg::IN_W-1:0]  s_tdata,
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [lsas_pkg::OUT_W-1:0] m_tdata,
    output int                         mismatch_count,
    output int                         due_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import lsas_pkg::*;

    // Same layout as m_tdata: advanced at the top, angle at the bottom.
    typedef struct packed {
        logic               adv;
        logic [STEP_W-1:0]  step;
        logic [IVL_W-1:0]   ivl;
        logic [ANGLE_W-1:0] angle;
    } stepper_out_t;

    logic [ANGLE_W-1:0] angle_now     = '0;
    logic [TICK_W-1:0]  last_adv_tick = '0;
    stepper_out_t       results_due[$];
    int                 reported      = 0;

    // First step size with the smallest rounding error wins.
    function automatic void pick_step(input int unsigned mag, input int dir,
                                      output int unsigned ivl, output int stp);
        int unsigned lim;
        int unsigned dv;
        int unsigned num;
        int unsigned rm;
        int unsigned q;
        int unsigned best_err;
        bit          have;
        lim      = MAX_STEP;
        dv       = mag << DEN_SHIFT;
        best_err = 0;
        have     = 0;
        ivl      = 1;
        stp      = 0;
        if (mag <= SMALL_MAG && lim > SMALL_LIMIT)
            lim = SMALL_LIMIT;
        for (int unsigned k = 1; k <= lim; k++)
        begin
            num = BASE_NUM * k;
            rm  = num % dv;
            q   = num / dv;
            // exactly half rounds down
            if (rm > (mag << HALF_SHIFT))
            begin
                rm = dv - rm;
                q  = q + 1;
            end
            if (!have || rm < best_err)
            begin
                have     = 1;
                best_err = rm;
                ivl      = q;
                stp      = int'(k) * dir;
            end
        end
    endfunction

    function automatic stepper_out_t advance_angle(input logic signed [SPEED_W-1:0] speed,
                                                   input logic [TICK_W-1:0] tick);
        stepper_out_t      r;
        int                spd;
        int unsigned       ivl;
        int                stp;
        int                a;
        logic [TICK_W-1:0] elapsed;
        r   = '0;
        spd = speed;
        ivl = 0;
        stp = 0;
        if (spd <= IGNORE_ABOVE)
        begin
            if (spd == 0)
                ivl = 1;
            else
                pick_step(spd < 0 ? -spd : spd, spd < 0 ? -1 : 1, ivl, stp);
            elapsed = tick - last_adv_tick;
            if (elapsed >= ivl)
            begin
                a = int'(angle_now) + stp;
                if (a >= ENCODER_COUNTS)
                    a -= ENCODER_COUNTS;
                if (a < 0)
                    a += ENCODER_COUNTS;
                angle_now     = a[ANGLE_W-1:0];
                last_adv_tick = tick;
                r.adv         = 1'b1;
            end
        end
        r.ivl   = ivl[IVL_W-1:0];
        r.step  = stp[STEP_W-1:0];
        r.angle = angle_now;
        return r;
    endfunction

    always @(posedge clk)
    begin
        stepper_out_t got;
        stepper_out_t want;
        if (rst_n)
        begin
            // result side first: a request taken this edge cannot finish this edge
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (results_due.size() == 0)
                begin
                    mismatch_count++;
                    if (reported < 10)
                        $display("%0t: unexpected result angle=%0d ivl=%0d step=%0d adv=%0d",
                                 $realtime, got.angle, got.ivl, $signed(got.step), got.adv);
                    reported++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (reported < 10)
                            $display({"%0t: mismatch exp angle=%0d ivl=%0d step=%0d adv=%0d",
                                      " got angle=%0d ivl=%0d step=%0d adv=%0d"},
                                     $realtime, want.angle, want.ivl, $signed(want.step),
                                     want.adv, got.angle, got.ivl, $signed(got.step), got.adv);
                        reported++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                results_due.push_back(advance_angle(s_tdata[SPEED_W-1:0],
                                                    s_tdata[IN_W-1:SPEED_W]));
            due_count = results_due.size();
        end
    end

endmodule

// ===== tb/sv/low_speed_angle_stepper_unit_tb.sv =====
module low_speed_angle_stepper_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lsas_pkg::*;

    // Cycles without any handshake before the run is declared hung. The slowest
    // request, the idle gaps on each side and the closing hold-off all stay
    // well inside this limit, so it leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1400;   // searched or zero-speed requests
    localparam int DRAIN_CYCLES   = 100;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;     // [7:0] speed_cmd (signed), [39:8] tick_now
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;     // [9:0] angle, [18:10] interval_ticks,
                                   // [22:19] angle_step (signed), [23] advanced

    int               mismatch_count;
    int               due_count;

    // Per-side idle ceilings; zero gives back-to-back stretches.
    int               tx_idle_max;
    int               rx_idle_max;
    logic [TICK_W-1:0] tick_base;

    low_speed_angle_stepper_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    lsas_angle_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .due_count      (due_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Single reset at time zero, released on a falling edge.
    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
    end

    // Result side: before each result, hold tready low for a stall drawn from 0..rx_idle_max.
    // A zero draw keeps tready high so back-to-back results drain every cycle.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, rx_idle_max);
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
        end
    end

    // Hang detector: ends the run when no request or result moves for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Offers one request after a random gap; returns at the accepting edge.
    // Valid is never lowered and raised on the same edge.
    task automatic push_request(input logic signed [SPEED_W-1:0] speed,
                                input logic [TICK_W-1:0] tick);
        int gap;
        gap = $urandom_range(0, tx_idle_max);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= {tick, speed};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
    endtask

    function automatic int pick_idle_max();
        int r;
        r = $urandom_range(0, 2);
        return (r == 0) ? 0 : (r == 1) ? 3 : 8;
    endfunction

    initial
    begin
        int                          searched;
        int                          n;
        int                          r;
        logic signed [SPEED_W-1:0]   speed;

        s_tvalid    = 1'b0;
        s_tdata     = '0;
        tx_idle_max = 8;
        rx_idle_max = 8;
        tick_base   = '0;
        @(posedge rst_n);

        // Directed part.
        push_request(8'sd0,    32'd0);          // zero speed, no tick elapsed
        push_request(8'sd0,    32'd1);          // zero speed advances, angle kept
        push_request(8'sd1,    32'd2);          // slowest, interval not yet reached
        push_request(8'sd1,    32'd400);        // slowest, advance
        push_request(-8'sd1,   32'd800);        // reverse steps the angle back to zero
        push_request(8'sd27,   32'd900);        // last magnitude with the short search
        push_request(8'sd28,   32'd1000);       // first magnitude with the full search
        push_request(-8'sd27,  32'd1100);
        push_request(-8'sd28,  32'd1200);
        push_request(8'sd50,   32'd1300);       // highest accepted speed
        push_request(8'sd51,   32'd5000);       // ignored
        push_request(8'sd127,  32'hFFFF_FFFF);  // ignored, all tick bits set
        push_request(-8'sd128, 32'd1301);       // most negative, magnitude 128
        push_request(-8'sd128, 32'd1400);
        push_request(8'sd49,   32'd1401);
        push_request(-8'sd50,  32'd1500);
        push_request(8'sd5,    32'hFFFF_FFF0);  // large jump forward
        push_request(8'sd5,    32'h0000_0100);  // elapsed count wraps past 2^32
        push_request(8'sd13,   32'h0000_0101);
        push_request(-8'sd5,   32'h0000_0200);
        push_request(8'sd2,    32'h0000_0300);
        push_request(-8'sd3,   32'h0000_0400);
        tick_base = 32'h0000_0400;

        // Random part: mostly valid speeds with slowly rising ticks so both
        // advance and hold decisions come up often.
        searched = 0;
        n        = 0;
        while (searched < RANDOM_ITEMS)
        begin
            if (n % 128 == 0)
            begin
                tx_idle_max = pick_idle_max();
                rx_idle_max = pick_idle_max();
            end
            // Let the pipeline empty completely, twice in the run.
            if (n == 400 || n == 1000)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                wait (due_count == 0);
            end
            // Push the tick count up against the 2^32 wrap once.
            if (n == 700)
                tick_base = 32'hFFFF_F000;

            r = $urandom_range(0, 99);
            if (r < 8)
                speed = SPEED_W'($urandom_range(51, 127));
            else if (r < 13)
                speed = 8'sd0;
            else
            begin
                speed = SPEED_W'($urandom_range(0, 177) - 128);
                if (speed >= 0)
                    speed = speed + 8'sd1;
            end

            r = $urandom_range(0, 99);
            if (r < 5)
                tick_base = $urandom;
            else if (r < 15)
                tick_base = tick_base + $urandom_range(0, 3);
            else
                tick_base = tick_base + $urandom_range(0, 400);

            push_request(speed, tick_base);
            if (speed <= IGNORE_ABOVE)
                searched++;
            n++;
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (due_count == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && due_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
